>>> hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and constants for the 3D vector normalization pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int unsigned SQ_STAGES  = 32;  // one root bit per stage
    localparam int unsigned DIV_STAGES = 31;  // one quotient bit per stage
    localparam int unsigned LANES      = 3;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } vec_in_t;

    typedef struct packed {
        logic signed [31:0] x_unit;
        logic signed [31:0] y_unit;
        logic signed [31:0] z_unit;
        logic        [31:0] vec_length;
        logic               zero_vector;
    } vec_out_t;

    // per-item side data carried alongside the root computation
    typedef struct packed {
        logic [LANES-1:0]       neg;
        logic [LANES-1:0][31:0] mag;
    } side_t;

endpackage

>>> hw/rtl/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square
// Magnitudes, squares and sum of squares over three register stages.
// ----------------------------------------------------------------------------
module vn_square (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  vn_pkg::vec_in_t   in_data,
    output logic              out_vld,
    output logic [63:0]       out_sum,
    output vn_pkg::side_t     out_side
);

    logic [2:0]           vld_reg;
    vn_pkg::side_t        side1_reg;
    vn_pkg::side_t        side2_reg;
    vn_pkg::side_t        side3_reg;
    logic [2:0][63:0]     sq_reg;
    logic [63:0]          sum_reg;
    vn_pkg::side_t        side1_next;
    logic [2:0][31:0]     comp;

    // sign and magnitude of each component
    always_comb begin
        comp[0] = in_data.x_in;
        comp[1] = in_data.y_in;
        comp[2] = in_data.z_in;
        for (int l = 0; l < 3; l++) begin
            side1_next.neg[l] = comp[l][31];
            side1_next.mag[l] = comp[l][31] ? (~comp[l] + 32'd1) : comp[l];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    // data stages
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            for (int l = 0; l < 3; l++) begin
                sq_reg[l] <= 64'(side1_reg.mag[l]) * 64'(side1_reg.mag[l]);
            end
            side2_reg <= side1_reg;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            side3_reg <= side2_reg;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_sum  = sum_reg;
    assign out_side = side3_reg;

endmodule

>>> hw/rtl/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined digit-by-digit floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       in_sum,
    input  vn_pkg::side_t     in_side,
    output logic              out_vld,
    output logic [31:0]       out_len,
    output vn_pkg::side_t     out_side
);

    localparam int unsigned N = vn_pkg::SQ_STAGES;

    logic [N-1:0]         vld_reg;
    logic [63:0]          n_reg    [N];
    logic [33:0]          rem_reg  [N];
    logic [31:0]          root_reg [N];
    vn_pkg::side_t        side_reg [N];
    logic [63:0]          n_next    [N];
    logic [33:0]          rem_next  [N];
    logic [31:0]          root_next [N];

    // one recurrence step per stage, stages independent
    always_comb begin
        logic [63:0] n_cur;
        logic [33:0] rem_cur;
        logic [31:0] root_cur;
        logic [35:0] shifted;
        logic [35:0] trial;
        for (int s = 0; s < N; s++) begin
            n_cur    = (s == 0) ? in_sum : n_reg[(s == 0) ? 0 : s - 1];
            rem_cur  = (s == 0) ? 34'd0  : rem_reg[(s == 0) ? 0 : s - 1];
            root_cur = (s == 0) ? 32'd0  : root_reg[(s == 0) ? 0 : s - 1];
            shifted  = {rem_cur, n_cur[63:62]};
            trial    = {2'b00, root_cur, 2'b01};
            n_next[s] = {n_cur[61:0], 2'b00};
            if (shifted >= trial) begin
                rem_next[s]  = 34'(shifted - trial);
                root_next[s] = {root_cur[30:0], 1'b1};
            end else begin
                rem_next[s]  = shifted[33:0];
                root_next[s] = {root_cur[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < N; s++) begin
                n_reg[s]    <= n_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                side_reg[s] <= (s == 0) ? in_side : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_len  = root_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

>>> hw/rtl/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// Three-lane pipelined restoring divider: (mag << 30) / len, one bit a stage.
// ----------------------------------------------------------------------------
module vn_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [31:0]       in_len,
    input  vn_pkg::side_t     in_side,
    output logic              out_vld,
    output vn_pkg::vec_out_t  out_data
);

    localparam int unsigned N = vn_pkg::DIV_STAGES;
    localparam int unsigned L = vn_pkg::LANES;

    logic [N-1:0]           vld_reg;
    logic [31:0]            len_reg [N];
    logic [L-1:0]           neg_reg [N];
    logic [L-1:0][31:0]     rem_reg [N];
    logic [L-1:0][N-1:0]    quo_reg [N];
    logic [L-1:0][31:0]     rem_next [N];
    logic [L-1:0][N-1:0]    quo_next [N];
    logic [L-1:0][31:0]     unit;
    logic                   is_zero;

    // one quotient bit per stage per lane; mag <= len keeps the quotient in 31 bits
    always_comb begin
        logic [31:0]  len_cur;
        logic [31:0]  rem_cur;
        logic [N-1:0] quo_cur;
        logic [32:0]  shifted;
        for (int s = 0; s < N; s++) begin
            len_cur = (s == 0) ? in_len : len_reg[(s == 0) ? 0 : s - 1];
            for (int l = 0; l < L; l++) begin
                if (s == 0) begin
                    rem_cur = {1'b0, in_side.mag[l][31:1]};
                    quo_cur = '0;
                    shifted = {rem_cur, in_side.mag[l][0]};
                end else begin
                    rem_cur = rem_reg[(s == 0) ? 0 : s - 1][l];
                    quo_cur = quo_reg[(s == 0) ? 0 : s - 1][l];
                    shifted = {rem_cur, 1'b0};
                end
                if (shifted >= {1'b0, len_cur}) begin
                    rem_next[s][l] = 32'(shifted - {1'b0, len_cur});
                    quo_next[s][l] = {quo_cur[N-2:0], 1'b1};
                end else begin
                    rem_next[s][l] = shifted[31:0];
                    quo_next[s][l] = {quo_cur[N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < N; s++) begin
                len_reg[s] <= (s == 0) ? in_len : len_reg[(s == 0) ? 0 : s - 1];
                neg_reg[s] <= (s == 0) ? in_side.neg : neg_reg[(s == 0) ? 0 : s - 1];
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    // sign restore, zero vector forces zero units
    always_comb begin
        is_zero = (len_reg[N-1] == 32'd0);
        for (int l = 0; l < L; l++) begin
            if (is_zero) begin
                unit[l] = '0;
            end else if (neg_reg[N-1][l]) begin
                unit[l] = 32'd0 - {1'b0, quo_reg[N-1][l]};
            end else begin
                unit[l] = {1'b0, quo_reg[N-1][l]};
            end
        end
        out_data.x_unit      = unit[0];
        out_data.y_unit      = unit[1];
        out_data.z_unit      = unit[2];
        out_data.vec_length  = len_reg[N-1];
        out_data.zero_vector = is_zero;
    end

    assign out_vld = vld_reg[N-1];

endmodule

>>> hw/rtl/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes one signed Q15.16 3D vector per cycle, while the output is not stalled, to Q1.30 unit components.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one vector per transaction (x, y, z in Q15.16).
//   m_valid/m_ready/m_data return one result per transaction: the unit
//   components in Q1.30 truncated toward zero, the floor length in Q16.16 and
//   a zero_vector flag (all-zero input gives zero units and zero length).
//   The pipeline computes magnitudes, squares and sum, then the
//   square root (one root bit per stage), then the three parallel
//   dividers (one quotient bit per stage).
//   Throughput is one transaction per cycle while m_ready is high.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds; s_ready follows, so nothing is lost or repeated. A bubble at the
//   output lets the pipeline advance regardless of m_ready.
//   A synchronous reset (aresetn low) clears all valid bits; data in flight
//   is dropped and m_valid is low after reset.
// ----------------------------------------------------------------------------
module vector3_normalize (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vn_pkg::vec_in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vn_pkg::vec_out_t  m_data
);

    logic           en;
    logic           sq_vld;
    logic [63:0]    sq_sum;
    vn_pkg::side_t  sq_side;
    logic           rt_vld;
    logic [31:0]    rt_len;
    vn_pkg::side_t  rt_side;

    // pipeline advances unless a finished result is being held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    vn_square u_square (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .in_data  (s_data),
        .out_vld  (sq_vld),
        .out_sum  (sq_sum),
        .out_side (sq_side)
    );

    vn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld),
        .in_sum   (sq_sum),
        .in_side  (sq_side),
        .out_vld  (rt_vld),
        .out_len  (rt_len),
        .out_side (rt_side)
    );

    vn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (rt_vld),
        .in_len   (rt_len),
        .in_side  (rt_side),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

    // zero vector gives all-zero units and length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_vector |->
            m_data.x_unit == 0 && m_data.y_unit == 0 && m_data.z_unit == 0 &&
            m_data.vec_length == 0)
        else $error("zero vector result not cleared");

    // nonzero vector has nonzero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_vector |-> m_data.vec_length != 0)
        else $error("nonzero vector with zero length");

    // unit components within [-1.0, 1.0]
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.x_unit <= 32'sd1073741824 && m_data.x_unit >= -32'sd1073741824 &&
            m_data.y_unit <= 32'sd1073741824 && m_data.y_unit >= -32'sd1073741824 &&
            m_data.z_unit <= 32'sd1073741824 && m_data.z_unit >= -32'sd1073741824)
        else $error("unit component out of range");

    // no result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
